/* src/stt_pkg.sv */
// Shared types, constants and character classes for the source text tokenizer.
// Depends on nothing; every other file of the block imports it.
package stt_pkg;

    // Default sizes
    localparam int MAX_TOKEN_LEN_DEF = 128;
    localparam int COUNT_BITS_DEF    = 16;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int TOTAL_W = 16;

    // Token kinds as carried on the result channel
    localparam logic [KIND_W-1:0] KIND_NUM    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SYM    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd5;

    // Characters with a role of their own
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_BANG    = 8'h21;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  ch;
        logic               done;
        logic               empty;
        logic               unterm;
        logic [TOTAL_W-1:0] total;
        logic               run_last;
    } token_res_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    // ( ) { } [ ] ; , . + - * / % & | ^ ! = < >
    function automatic logic is_symbol(input logic [CHAR_W-1:0] b);
        logic hit;
        case (b) inside
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2E,
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h26, 8'h7C, 8'h5E, 8'h21,
            8'h3D, 8'h3C, 8'h3E: hit = 1'b1;
            default:             hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* src/stt_text_if.sv */
// Input channel of the tokenizer: one text byte per beat, valid/ready handshake.
// Depends on stt_pkg for the character width.
interface stt_text_if;
    import stt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

/* src/stt_token_if.sv */
// Result channel of the tokenizer: one token character per beat, valid/ready handshake.
// Depends on stt_pkg for field widths.
interface stt_token_if;
    import stt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [CHAR_W-1:0]  token_char;
    logic               token_done;
    logic               empty_string;
    logic               unterminated;
    logic [TOTAL_W-1:0] token_total;
    logic               run_last;

    modport source (output valid, output token_kind, output token_char, output token_done,
                    output empty_string, output unterminated, output token_total,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_char, input token_done,
                    input empty_string, input unterminated, input token_total,
                    input run_last, output ready);
endinterface

/* src/source_text_tokenizer.sv */
// Streaming tokenizer: classifies text bytes and emits tagged token characters.
// Depends on stt_pkg, stt_text_if and stt_token_if.
//
//   channel    dir  beat
//   text_in    in   text_byte (0 ends the text)
//   token_out  out  token_kind, token_char, token_done, empty_string,
//                   unterminated, token_total, run_last
//
// Each text byte is classified in the cycle it is accepted; its zero, one or
// two result beats land in a four-entry result queue on that same edge.
// A byte is taken whenever the queue has room for two beats, so one byte per
// cycle is sustained while results drain; a byte that makes two beats leaves
// two beats to drain. Reset clears the scanner state, tally and queue.
// A stalled result channel fills the queue past two beats and then holds text_in.ready low.
module source_text_tokenizer #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int COUNT_BITS    = stt_pkg::COUNT_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    stt_text_if.sink    text_in,
    stt_token_if.source token_out
);
    import stt_pkg::*;

    localparam int LEN_W      = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN) : 1;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam logic [LEN_W-1:0]      LEN_LAST  = LEN_W'(MAX_TOKEN_LEN - 1);
    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_STR,
        MODE_OP
    } scan_mode_t;

    scan_mode_t             mode_reg,       mode_next;
    logic [CHAR_W-1:0]      held_char_reg,  held_char_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   quote_reg,      quote_next;
    logic [LEN_W-1:0]       len_reg,        len_next;
    logic [COUNT_BITS-1:0]  tally_reg,      tally_next;

    token_res_t             q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]     cnt_reg,    cnt_next;

    token_res_t             res [2];
    logic [1:0]             res_cnt;
    logic                   in_fire;
    logic                   out_fire;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == TALLY_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic token_res_t make_res(input logic [KIND_W-1:0] kind,
                                            input logic [CHAR_W-1:0] ch,
                                            input logic done,
                                            input logic empty,
                                            input logic unterm,
                                            input logic [TOTAL_W-1:0] total);
        token_res_t r;
        r.kind     = kind;
        r.ch       = ch;
        r.done     = done;
        r.empty    = empty;
        r.unterm   = unterm;
        r.total    = total;
        r.run_last = 1'b0;
        return r;
    endfunction

    // Handshakes
    assign in_fire        = text_in.valid & text_in.ready;
    assign out_fire       = token_out.valid & token_out.ready;
    assign text_in.ready  = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign token_out.valid = (cnt_reg != '0);

    // Classify one byte against the scanner state
    always_comb
    begin
        logic [CHAR_W-1:0] b;
        logic [CHAR_W-1:0] closer;
        logic [KIND_W-1:0] kind;
        logic [31:0]       tally_ext;
        logic              same;
        logic              do_start;

        b               = text_in.text_byte;
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        quote_next      = quote_reg;
        len_next        = len_reg;
        tally_next      = tally_reg;
        res[0]          = make_res(KIND_NUM, CHAR_NUL, 1'b0, 1'b0, 1'b0, '0);
        res[1]          = res[0];
        res_cnt         = 2'd0;
        do_start        = 1'b0;
        kind            = (mode_reg == MODE_NUM) ? KIND_NUM : KIND_IDENT;
        same            = (mode_reg == MODE_NUM) ? is_digit(b) : is_alpha(b);
        closer          = quote_reg ? CHAR_SQUOTE : CHAR_DQUOTE;

        case (mode_reg)
            MODE_NUM, MODE_IDENT:
            begin
                if (same)
                begin
                    // Emit the held character; split the token at the length limit
                    if (len_next == LEN_LAST)
                    begin
                        res[0]     = make_res(kind, held_char_reg, 1'b1, 1'b0, 1'b0, '0);
                        len_next   = '0;
                        tally_next = sat_inc(tally_next);
                    end
                    else
                    begin
                        res[0]   = make_res(kind, held_char_reg, 1'b0, 1'b0, 1'b0, '0);
                        len_next = len_next + LEN_W'(1);
                    end
                    res_cnt         = 2'd1;
                    held_char_next  = b;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    res[0]     = make_res(kind, held_char_reg, 1'b1, 1'b0, 1'b0, '0);
                    res_cnt    = 2'd1;
                    tally_next = sat_inc(tally_next);
                    do_start   = 1'b1;
                end
            end
            MODE_STR:
            begin
                if (b == closer)
                begin
                    // Close the string, or report it empty
                    if (held_valid_reg)
                        res[0] = make_res(KIND_STR, held_char_reg, 1'b1, 1'b0, 1'b0, '0);
                    else
                        res[0] = make_res(KIND_STR, CHAR_NUL, 1'b1, 1'b1, 1'b0, '0);
                    res_cnt         = 2'd1;
                    tally_next      = sat_inc(tally_next);
                    mode_next       = MODE_IDLE;
                    held_valid_next = 1'b0;
                    len_next        = '0;
                end
                else if (b == CHAR_NUL)
                begin
                    // Text ended inside the string
                    res[0]     = make_res(KIND_STR, held_valid_reg ? held_char_reg : CHAR_NUL,
                                          1'b1, 1'b0, 1'b1, '0);
                    res_cnt    = 2'd1;
                    tally_next = sat_inc(tally_next);
                    do_start   = 1'b1;
                end
                else
                begin
                    if (held_valid_reg)
                    begin
                        if (len_next == LEN_LAST)
                        begin
                            res[0]     = make_res(KIND_STR, held_char_reg, 1'b1, 1'b0, 1'b0, '0);
                            len_next   = '0;
                            tally_next = sat_inc(tally_next);
                        end
                        else
                        begin
                            res[0]   = make_res(KIND_STR, held_char_reg, 1'b0, 1'b0, 1'b0, '0);
                            len_next = len_next + LEN_W'(1);
                        end
                        res_cnt = 2'd1;
                    end
                    held_char_next  = b;
                    held_valid_next = 1'b1;
                end
            end
            MODE_OP:
            begin
                if (b == CHAR_EQUAL)
                begin
                    res[0]          = make_res(KIND_DOUBLE, held_char_reg, 1'b0, 1'b0, 1'b0, '0);
                    res[1]          = make_res(KIND_DOUBLE, b, 1'b1, 1'b0, 1'b0, '0);
                    res_cnt         = 2'd2;
                    tally_next      = sat_inc(tally_next);
                    mode_next       = MODE_IDLE;
                    held_valid_next = 1'b0;
                    len_next        = '0;
                end
                else
                begin
                    // Lone = or ! goes out as a symbol
                    res[0]     = make_res(KIND_SYM, held_char_reg, 1'b1, 1'b0, 1'b0, '0);
                    res_cnt    = 2'd1;
                    tally_next = sat_inc(tally_next);
                    do_start   = 1'b1;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Handle the byte as the start of a new token
        tally_ext = 32'(tally_next);
        if (do_start)
        begin
            mode_next       = MODE_IDLE;
            held_valid_next = 1'b0;
            len_next        = '0;
            if (b == CHAR_NUL)
            begin
                res[res_cnt[0]] = make_res(KIND_END, CHAR_NUL, 1'b0, 1'b0, 1'b0,
                                           (tally_ext > 32'hFFFF) ? 16'hFFFF
                                                                   : tally_ext[TOTAL_W-1:0]);
                res_cnt    = res_cnt + 2'd1;
                tally_next = '0;
            end
            else if ((b == CHAR_SPACE) || (b == CHAR_NEWLINE))
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_digit(b))
            begin
                mode_next       = MODE_NUM;
                held_char_next  = b;
                held_valid_next = 1'b1;
            end
            else if (is_alpha(b))
            begin
                mode_next       = MODE_IDENT;
                held_char_next  = b;
                held_valid_next = 1'b1;
            end
            else if ((b == CHAR_DQUOTE) || (b == CHAR_SQUOTE))
            begin
                mode_next  = MODE_STR;
                quote_next = (b == CHAR_SQUOTE);
            end
            else if ((b == CHAR_EQUAL) || (b == CHAR_BANG))
            begin
                mode_next       = MODE_OP;
                held_char_next  = b;
                held_valid_next = 1'b1;
            end
            else if (is_symbol(b))
            begin
                res[res_cnt[0]] = make_res(KIND_SYM, b, 1'b1, 1'b0, 1'b0, '0);
                res_cnt         = res_cnt + 2'd1;
                tally_next      = sat_inc(tally_next);
            end
        end

        // Mark the last beat of this byte
        if (res_cnt == 2'd1)
            res[0].run_last = 1'b1;
        else if (res_cnt == 2'd2)
            res[1].run_last = 1'b1;
    end

    // Queue pointers and fill level
    always_comb
    begin
        logic [1:0] push;
        push        = in_fire ? res_cnt : 2'd0;
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(out_fire);
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(out_fire);
    end

    // Hold scanner state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            quote_reg      <= 1'b0;
            len_reg        <= '0;
            tally_reg      <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg       <= mode_next;
                held_char_reg  <= held_char_next;
                held_valid_reg <= held_valid_next;
                quote_reg      <= quote_next;
                len_reg        <= len_next;
                tally_reg      <= tally_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write result beats into the queue
    always_ff @(posedge clk)
    begin
        if (in_fire && (res_cnt != 2'd0))
            q_reg[wr_ptr_reg] <= res[0];
        if (in_fire && (res_cnt == 2'd2))
            q_reg[wr_ptr_reg + Q_PTR_W'(1)] <= res[1];
    end

    // Drive the head beat
    assign token_out.token_kind   = q_reg[rd_ptr_reg].kind;
    assign token_out.token_char   = q_reg[rd_ptr_reg].ch;
    assign token_out.token_done   = q_reg[rd_ptr_reg].done;
    assign token_out.empty_string = q_reg[rd_ptr_reg].empty;
    assign token_out.unterminated = q_reg[rd_ptr_reg].unterm;
    assign token_out.token_total  = q_reg[rd_ptr_reg].total;
    assign token_out.run_last     = q_reg[rd_ptr_reg].run_last;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for source_text_tokenizer: drives text bytes, predicts token beats.
// Depends on stt_pkg, stt_text_if, stt_token_if and the source_text_tokenizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import stt_pkg::*;

    localparam int         LONG_STALL = 300;
    localparam token_res_t NO_TOK     = '0;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_NUM,
        LEX_IDENT,
        LEX_STR,
        LEX_OP
    } lex_mode_t;

    // One directed row: the text byte and, where fixed, the beats it must produce
    typedef struct {
        logic [CHAR_W-1:0] b;
        int                n_typed;
        token_res_t        t0;
        token_res_t        t1;
    } text_row_t;

    logic clk;
    logic rst_n;

    stt_text_if  text_ch ();
    stt_token_if token_ch ();

    source_text_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch),
        .token_out (token_ch)
    );

    // Lexer state of the predictor
    lex_mode_t         lex_mode;
    logic [CHAR_W-1:0] carry_char;
    bit                carry_valid;
    bit                quote_single;
    int unsigned       run_len;
    int unsigned       token_count;

    token_res_t pending_tokens [$];
    string      punct_chars = "(){}[];,.+-*/%&|^!=<>";

    int  send_idle_pct;
    int  recv_idle_pct;
    int  bytes_sent;
    int  mismatch_count;
    bit  hold_req;

    // Directed text: fixed beats only where they are plain to see
    text_row_t plan [26] = '{
        '{CHAR_NUL, 1, '{KIND_END, CHAR_NUL, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1}, NO_TOK},
        '{"(", 1, '{KIND_SYM, "(", 1'b1, 1'b0, 1'b0, 16'd0, 1'b1}, NO_TOK},
        '{CHAR_DQUOTE, 0, NO_TOK, NO_TOK},
        '{CHAR_DQUOTE, 1, '{KIND_STR, CHAR_NUL, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1}, NO_TOK},
        '{"9", 0, NO_TOK, NO_TOK},
        '{"0", 0, NO_TOK, NO_TOK},
        '{"z", 0, NO_TOK, NO_TOK},
        '{"A", 0, NO_TOK, NO_TOK},
        '{CHAR_EQUAL, 0, NO_TOK, NO_TOK},
        '{CHAR_EQUAL, 0, NO_TOK, NO_TOK},
        '{CHAR_SPACE, 0, NO_TOK, NO_TOK},
        '{CHAR_BANG, 0, NO_TOK, NO_TOK},
        '{CHAR_EQUAL, 0, NO_TOK, NO_TOK},
        '{CHAR_BANG, 0, NO_TOK, NO_TOK},
        '{"x", 0, NO_TOK, NO_TOK},
        '{CHAR_SQUOTE, 0, NO_TOK, NO_TOK},
        '{8'hFF, 0, NO_TOK, NO_TOK},
        '{CHAR_DQUOTE, 0, NO_TOK, NO_TOK},
        '{8'h01, 0, NO_TOK, NO_TOK},
        '{CHAR_SQUOTE, 0, NO_TOK, NO_TOK},
        '{8'h80, 0, NO_TOK, NO_TOK},
        '{CHAR_EQUAL, 0, NO_TOK, NO_TOK},
        '{CHAR_NEWLINE, 0, NO_TOK, NO_TOK},
        '{CHAR_DQUOTE, 0, NO_TOK, NO_TOK},
        '{"q", 0, NO_TOK, NO_TOK},
        '{CHAR_NUL, 2, '{KIND_STR, "q", 1'b1, 1'b0, 1'b1, 16'd0, 1'b0},
                       '{KIND_END, CHAR_NUL, 1'b0, 1'b0, 1'b0, 16'd11, 1'b1}}
    };

    // Character classes
    function automatic bit is_numeral(input logic [CHAR_W-1:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic bit is_letter(input logic [CHAR_W-1:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic bit is_punct(input logic [CHAR_W-1:0] b);
        for (int i = 0; i < punct_chars.len(); i++)
            if (punct_chars[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void put_token(input logic [KIND_W-1:0] kind,
                                      input logic [CHAR_W-1:0] ch, input bit done,
                                      input bit empty, input bit unterm,
                                      input logic [TOTAL_W-1:0] total);
        pending_tokens.push_back('{kind, ch, done, empty, unterm, total, 1'b0});
    endfunction

    // Saturating tally
    function automatic void count_token();
        longint unsigned tally_max;
        tally_max = (64'd1 << COUNT_BITS_DEF) - 1;
        if (token_count < tally_max)
            token_count++;
    endfunction

    // Emit the held character mid-token; a full token closes on it
    function automatic void extend_run(input logic [KIND_W-1:0] kind);
        bit done;
        done = 1'b0;
        run_len++;
        if (run_len >= MAX_TOKEN_LEN_DEF)
        begin
            done    = 1'b1;
            run_len = 0;
            count_token();
        end
        put_token(kind, carry_char, done, 1'b0, 1'b0, '0);
    endfunction

    function automatic void close_run(input logic [KIND_W-1:0] kind);
        put_token(kind, carry_char, 1'b1, 1'b0, 1'b0, '0);
        count_token();
        lex_mode    = LEX_IDLE;
        carry_valid = 1'b0;
        run_len     = 0;
    endfunction

    // Byte seen with no token open
    function automatic void open_token(input logic [CHAR_W-1:0] b);
        lex_mode    = LEX_IDLE;
        carry_valid = 1'b0;
        run_len     = 0;
        if (b == CHAR_NUL)
        begin
            put_token(KIND_END, CHAR_NUL, 1'b0, 1'b0, 1'b0,
                      (token_count > 32'hFFFF) ? 16'hFFFF : token_count[TOTAL_W-1:0]);
            token_count = 0;
        end
        else if (b == CHAR_SPACE || b == CHAR_NEWLINE)
        begin
            // separator only
        end
        else if (is_numeral(b))
        begin
            lex_mode    = LEX_NUM;
            carry_char  = b;
            carry_valid = 1'b1;
        end
        else if (is_letter(b))
        begin
            lex_mode    = LEX_IDENT;
            carry_char  = b;
            carry_valid = 1'b1;
        end
        else if (b == CHAR_DQUOTE || b == CHAR_SQUOTE)
        begin
            lex_mode     = LEX_STR;
            quote_single = (b == CHAR_SQUOTE);
        end
        else if (b == CHAR_EQUAL || b == CHAR_BANG)
        begin
            lex_mode    = LEX_OP;
            carry_char  = b;
            carry_valid = 1'b1;
        end
        else if (is_punct(b))
        begin
            put_token(KIND_SYM, b, 1'b1, 1'b0, 1'b0, '0);
            count_token();
        end
    endfunction

    // Advance the lexer by one byte; returns how many beats it queued
    function automatic int lex_byte(input logic [CHAR_W-1:0] b);
        int                n0;
        logic [KIND_W-1:0] run_kind;
        logic [CHAR_W-1:0] closer;
        bit                same;
        token_res_t        tail;
        n0 = pending_tokens.size();
        case (lex_mode)
            LEX_NUM, LEX_IDENT:
            begin
                run_kind = (lex_mode == LEX_NUM) ? KIND_NUM : KIND_IDENT;
                same     = (lex_mode == LEX_NUM) ? is_numeral(b) : is_letter(b);
                if (same)
                begin
                    extend_run(run_kind);
                    carry_char  = b;
                    carry_valid = 1'b1;
                end
                else
                begin
                    close_run(run_kind);
                    open_token(b);
                end
            end
            LEX_STR:
            begin
                closer = quote_single ? CHAR_SQUOTE : CHAR_DQUOTE;
                if (b == closer)
                begin
                    if (carry_valid)
                        close_run(KIND_STR);
                    else
                    begin
                        put_token(KIND_STR, CHAR_NUL, 1'b1, 1'b1, 1'b0, '0);
                        count_token();
                    end
                    lex_mode    = LEX_IDLE;
                    carry_valid = 1'b0;
                    run_len     = 0;
                end
                else if (b == CHAR_NUL)
                begin
                    put_token(KIND_STR, carry_valid ? carry_char : CHAR_NUL,
                              1'b1, 1'b0, 1'b1, '0);
                    count_token();
                    open_token(CHAR_NUL);
                end
                else
                begin
                    if (carry_valid)
                        extend_run(KIND_STR);
                    carry_char  = b;
                    carry_valid = 1'b1;
                end
            end
            LEX_OP:
            begin
                if (b == CHAR_EQUAL)
                begin
                    put_token(KIND_DOUBLE, carry_char, 1'b0, 1'b0, 1'b0, '0);
                    put_token(KIND_DOUBLE, b, 1'b1, 1'b0, 1'b0, '0);
                    count_token();
                    lex_mode    = LEX_IDLE;
                    carry_valid = 1'b0;
                    run_len     = 0;
                end
                else
                begin
                    close_run(KIND_SYM);
                    open_token(b);
                end
            end
            default: open_token(b);
        endcase
        // Mark the last beat of this byte
        if (pending_tokens.size() > n0)
        begin
            tail          = pending_tokens.pop_back();
            tail.run_last = 1'b1;
            pending_tokens.push_back(tail);
        end
        return pending_tokens.size() - n0;
    endfunction

    // Offer one byte until accepted, then queue its beats
    task automatic send_byte(input logic [CHAR_W-1:0] b, input int n_typed = 0,
                             input token_res_t t0 = '0, input token_res_t t1 = '0);
        int produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        do
            @(posedge clk);
        while (!text_ch.ready);
        bytes_sent++;
        produced = lex_byte(b);
        // Fixed beats stand in for the predicted ones
        if (n_typed > 0)
        begin
            repeat (produced) void'(pending_tokens.pop_back());
            pending_tokens.push_back(t0);
            if (n_typed > 1)
                pending_tokens.push_back(t1);
        end
    endtask

    // One random piece of source text, mostly well-formed tokens
    task automatic send_snippet();
        int                pick;
        int                len;
        logic [CHAR_W-1:0] closer;
        logic [CHAR_W-1:0] c;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            len = ($urandom_range(99) == 0) ? $urandom_range(120, 260) : $urandom_range(1, 6);
            repeat (len) send_byte(CHAR_W'(8'h30 + $urandom_range(9)));
        end
        else if (pick < 40)
        begin
            len = ($urandom_range(99) == 0) ? $urandom_range(120, 260) : $urandom_range(1, 6);
            repeat (len)
            begin
                c = CHAR_W'(8'h41 + $urandom_range(25));
                if ($urandom_range(1))
                    c = c + 8'h20;
                send_byte(c);
            end
        end
        else if (pick < 54)
        begin
            closer = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            if ($urandom_range(99) == 0)
                len = $urandom_range(126, 260);
            else
                len = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 8);
            send_byte(closer);
            repeat (len)
            begin
                c = CHAR_W'($urandom_range(1, 255));
                if (c == closer)
                    c = CHAR_SPACE;
                send_byte(c);
            end
            // leave some strings open
            if ($urandom_range(9) != 0)
                send_byte(closer);
        end
        else if (pick < 66)
        begin
            send_byte(punct_chars[$urandom_range(punct_chars.len() - 1)]);
        end
        else if (pick < 74)
        begin
            send_byte($urandom_range(1) ? CHAR_EQUAL : CHAR_BANG);
            send_byte(CHAR_EQUAL);
        end
        else if (pick < 82)
        begin
            send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE);
        end
        else if (pick < 90)
        begin
            send_byte(CHAR_W'($urandom_range(1, 255)));
        end
        else if (pick < 95)
        begin
            send_byte(CHAR_NUL);
        end
        else
        begin
            // string cut off by the end of the text
            closer = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            send_byte(closer);
            repeat ($urandom_range(0, 3))
            begin
                c = CHAR_W'($urandom_range(1, 255));
                if (c == closer)
                    c = 8'h41;
                send_byte(c);
            end
            send_byte(CHAR_NUL);
        end
        if ($urandom_range(1))
            send_byte(CHAR_SPACE);
    endtask

    task automatic send_random_text(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_snippet();
    endtask

    // Compare one accepted beat with the oldest expected one
    function automatic void take_token();
        token_res_t got;
        token_res_t want;
        got = '{token_ch.token_kind, token_ch.token_char, token_ch.token_done,
                token_ch.empty_string, token_ch.unterminated, token_ch.token_total,
                token_ch.run_last};
        if (pending_tokens.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected beat, expected none, got kind=%0d char=%02h",
                     $time, got.kind, got.ch);
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.done !== want.done ||
                got.empty !== want.empty || got.unterm !== want.unterm ||
                got.total !== want.total || got.run_last !== want.run_last)
            begin
                mismatch_count++;
                $display("%0t: beat mismatch, expected kind=%0d char=%02h done=%0b empty=%0b",
                         $time, want.kind, want.ch, want.done, want.empty);
                $display("    unterm=%0b total=%0d last=%0b, got kind=%0d char=%02h done=%0b",
                         want.unterm, want.total, want.run_last, got.kind, got.ch, got.done);
                $display("    empty=%0b unterm=%0b total=%0d last=%0b",
                         got.empty, got.unterm, got.total, got.run_last);
            end
        end
    endfunction

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result side: random back-pressure, one long hold on request
    initial
    begin
        token_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                token_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                token_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
                if (rst_n && token_ch.valid && token_ch.ready)
                    take_token();
            end
        end
    end

    // Stimulus
    initial
    begin
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        rst_n             = 1'b0;
        hold_req          = 1'b0;
        bytes_sent        = 0;
        mismatch_count    = 0;
        lex_mode          = LEX_IDLE;
        carry_char        = '0;
        carry_valid       = 1'b0;
        quote_single      = 1'b0;
        run_len           = 0;
        token_count       = 0;
        send_idle_pct     = 8;
        recv_idle_pct     = 82;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text, then random with a slow receiver
        foreach (plan[i])
            send_byte(plan[i].b, plan[i].n_typed, plan[i].t0, plan[i].t1);
        send_random_text(500);

        // Slow sender
        send_idle_pct = 82;
        recv_idle_pct = 8;
        send_random_text(500);

        // Full rate; hold the result side long enough to stall the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        send_random_text(200);
        send_random_text(300);

        // End the text
        send_byte(CHAR_NUL);
        text_ch.valid <= 1'b0;

        // Drain
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("[source_text_tokenizer] OK");
        else
            $display("[source_text_tokenizer] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("[source_text_tokenizer] ERROR");
        $finish;
    end

endmodule

/* source_text_tokenizer.f */
src/stt_pkg.sv
src/stt_text_if.sv
src/stt_token_if.sv
src/source_text_tokenizer.sv
verif/tb_top.sv
